### rtl/core/midi_tep_pkg.sv
// Package for the track event parser: phase, kind and problem codes, the result record,
// and the small decode tables for meta lengths and the sysex reset patterns.
// No dependencies.
package midi_tep_pkg;

  localparam int unsigned META_STORE_LIMIT = 1024;
  localparam int unsigned VARLEN_MAX_BYTES = 4;
  localparam int unsigned OUT_DATA_W       = 136;
  localparam int unsigned FIFO_DEPTH       = 4;

  // Parser phases
  localparam logic [3:0] PH_DELTA  = 4'd0;
  localparam logic [3:0] PH_STATUS = 4'd1;
  localparam logic [3:0] PH_DATA1  = 4'd2;
  localparam logic [3:0] PH_DATA2  = 4'd3;
  localparam logic [3:0] PH_MTYPE  = 4'd4;
  localparam logic [3:0] PH_MLEN   = 4'd5;
  localparam logic [3:0] PH_MBODY  = 4'd6;
  localparam logic [3:0] PH_SLEN   = 4'd7;
  localparam logic [3:0] PH_SBODY  = 4'd8;

  // Result kinds
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_CHANNEL = 3'd1;
  localparam logic [2:0] KIND_META    = 3'd2;
  localparam logic [2:0] KIND_SYSEX   = 3'd3;
  localparam logic [2:0] KIND_EOT     = 3'd4;
  localparam logic [2:0] KIND_WARN    = 3'd5;

  // Problem codes
  localparam logic [1:0] PROB_NONE     = 2'd0;
  localparam logic [1:0] PROB_META_LEN = 2'd1;
  localparam logic [1:0] PROB_UNKNOWN  = 2'd2;
  localparam logic [1:0] PROB_DELTA    = 2'd3;

  // Meta types with special handling
  localparam logic [7:0] META_SEQ_NUM   = 8'h00;
  localparam logic [7:0] META_CHAN_PFX  = 8'h20;
  localparam logic [7:0] META_EOT       = 8'h2F;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_SMPTE     = 8'h54;
  localparam logic [7:0] META_TIME_SIG  = 8'h58;
  localparam logic [7:0] META_KEY_SIG   = 8'h59;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tick_time;
    logic [31:0] event_index;
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [7:0]  payload;
    logic [28:0] payload_length;
    logic [2:0]  standard;
    logic [1:0]  problem;
    logic        last;
  } res_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [31:0] tick,
                                  input logic [31:0] idx, input logic [7:0] st,
                                  input logic [7:0] d1, input logic [7:0] d2,
                                  input logic [7:0] pl, input logic [28:0] plen,
                                  input logic [2:0] stdv, input logic [1:0] prob);
    res_t r;
    r.kind           = kind;
    r.tick_time      = tick;
    r.event_index    = idx;
    r.status         = st;
    r.data_one       = d1;
    r.data_two       = d2;
    r.payload        = pl;
    r.payload_length = plen;
    r.standard       = stdv;
    r.problem        = prob;
    r.last           = 1'b0;
    return r;
  endfunction

  // Meta types that produce a meta result and payload
  function automatic logic meta_emitted(input logic [7:0] t);
    return !(t == META_SEQ_NUM || t == META_CHAN_PFX || t == META_EOT || t == META_SMPTE);
  endfunction

  // Length check against the fixed lengths of the well-known meta types
  function automatic logic meta_mismatch(input logic [7:0] t, input logic [28:0] len);
    logic m;
    case (t)
      META_SEQ_NUM:  m = (len != 29'd2) && (len != 29'd0);
      META_CHAN_PFX: m = (len != 29'd1);
      META_EOT:      m = (len != 29'd0);
      META_TEMPO:    m = (len != 29'd3);
      META_SMPTE:    m = (len != 29'd5);
      META_TIME_SIG: m = (len != 29'd4);
      META_KEY_SIG:  m = (len != 29'd2);
      default:       m = 1'b0;
    endcase
    return m;
  endfunction

  // Reset sysex lengths: GM1, GM2, GS, XG
  function automatic logic [28:0] pat_len(input logic [1:0] i);
    logic [28:0] l;
    case (i)
      2'd0:    l = 29'd6;
      2'd1:    l = 29'd6;
      2'd2:    l = 29'd11;
      default: l = 29'd9;
    endcase
    return l;
  endfunction

  // Reset sysex pattern bytes
  function automatic logic [7:0] pat_byte(input logic [1:0] i, input logic [3:0] p);
    logic [7:0] v;
    v = 8'h00;
    case (i)
      2'd0, 2'd1: begin
        case (p)
          4'd0:    v = 8'hF0;
          4'd1:    v = 8'h7E;
          4'd2:    v = 8'h7F;
          4'd3:    v = 8'h09;
          4'd4:    v = (i == 2'd0) ? 8'h01 : 8'h03;
          4'd5:    v = 8'hF7;
          default: v = 8'h00;
        endcase
      end
      2'd2: begin
        case (p)
          4'd0:    v = 8'hF0;
          4'd1:    v = 8'h41;
          4'd2:    v = 8'h10;
          4'd3:    v = 8'h42;
          4'd4:    v = 8'h12;
          4'd5:    v = 8'h40;
          4'd6:    v = 8'h00;
          4'd7:    v = 8'h7F;
          4'd8:    v = 8'h00;
          4'd9:    v = 8'h41;
          4'd10:   v = 8'hF7;
          default: v = 8'h00;
        endcase
      end
      default: begin
        case (p)
          4'd0:    v = 8'hF0;
          4'd1:    v = 8'h43;
          4'd2:    v = 8'h10;
          4'd3:    v = 8'h4C;
          4'd4:    v = 8'h00;
          4'd5:    v = 8'h00;
          4'd6:    v = 8'h7E;
          4'd7:    v = 8'h00;
          4'd8:    v = 8'hF7;
          default: v = 8'h00;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

### rtl/core/midi_track_event_parser.sv
// Standard MIDI file track event parser, top level.
// Depends on midi_tep_pkg.
//
// Usage: track body bytes arrive on the in_ channel, one per transfer;
// in_tuser flags a byte that starts a new track or a new file. Each byte
// is decoded in the cycle it is accepted and yields zero to two results,
// which enter a four-entry result queue feeding the out_ channel; out_tlast
// marks the final result caused by one input byte, out_tuser carries the
// result kind.
// Results are registered into the queue and are offered from its head in order.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver keeps up; in_tready is high while the queue holds at
// most one result, so the drain rate of the result queue sets the pace when
// bytes fan out into several results.
// Reset (rst_n low, synchronous) returns the parser to awaiting a delta,
// clears tick time, event count, running status and detected standard, and
// empties the queue. When the receiver stalls, queued results hold and
// in_tready drops once the queue cannot take three more.
module midi_track_event_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic [1:0]                          in_tuser,   // [0] track_start, [1] file_start
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] tick_time, [63:32] event_index, [71:64] status, [79:72] data_one,
  // [87:80] data_two, [95:88] payload, [124:96] payload_length,
  // [127:125] standard, [129:128] problem, [135:130] zero
  output logic [midi_tep_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]                          out_tuser,  // [2:0] kind
  output logic                                out_tlast
);
  import midi_tep_pkg::*;

  // Parser state
  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [7:0]  cs_r, cs_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] evc_r, evc_nxt;
  logic [27:0] vv_r, vv_nxt;
  logic [2:0]  vc_r, vc_nxt;
  logic [7:0]  fd_r, fd_nxt;
  logic [7:0]  mk_r, mk_nxt;
  logic [28:0] bl_r, bl_nxt;
  logic [28:0] bp_r, bp_nxt;
  logic [3:0]  hits_r, hits_nxt;
  logic [2:0]  std_r, std_nxt;
  logic        halt_r, halt_nxt;

  // Result queue
  res_t        q_r [FIFO_DEPTH];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;

  res_t        res [3];
  logic [1:0]  n_res;
  logic        in_fire, out_fire;
  logic [7:0]  b;
  res_t        head;

  assign b         = in_tdata;
  assign in_tready = (cnt_r <= 3'd1);
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_tvalid & out_tready;

  // Byte decode: up to two phase passes when running status applies
  always_comb begin
    logic        again, is_st, sx_do;
    logic [7:0]  t, sx_b;
    logic [2:0]  vcount;
    logic [28:0] len, total;

    phase_nxt = phase_r; rs_nxt = rs_r; cs_nxt = cs_r; tick_nxt = tick_r;
    evc_nxt = evc_r; vv_nxt = vv_r; vc_nxt = vc_r; fd_nxt = fd_r; mk_nxt = mk_r;
    bl_nxt = bl_r; bp_nxt = bp_r; hits_nxt = hits_r; std_nxt = std_r; halt_nxt = halt_r;
    n_res = 2'd0;
    for (int k = 0; k < 3; k++) res[k] = mk_res(3'd0, 32'd0, 32'd0, 8'd0, 8'd0, 8'd0,
                                               8'd0, 29'd0, 3'd0, 2'd0);
    again = 1'b0; is_st = 1'b0; sx_do = 1'b0; t = 8'd0; sx_b = 8'd0;
    vcount = 3'd0; len = 29'd0; total = 29'd0;

    if (in_tuser[1]) std_nxt = 3'd0;
    if (in_tuser[0] | in_tuser[1]) begin
      tick_nxt = 32'd0; evc_nxt = 32'd0; halt_nxt = 1'b0;
      phase_nxt = PH_DELTA; vv_nxt = 28'd0; vc_nxt = 3'd0;
    end

    for (int p = 0; p < 2; p++) begin
      if (!halt_nxt && (p == 0 || again)) begin
        again = 1'b0;
        sx_do = 1'b0;
        vcount = vc_nxt + 3'd1;
        case (phase_nxt)
          PH_DELTA: begin
            vc_nxt = vcount;
            if (vcount > 3'(VARLEN_MAX_BYTES)) begin
              res[n_res] = mk_res(KIND_WARN, tick_nxt, evc_nxt, cs_nxt, 8'd0, 8'd0, 8'd0,
                                  29'd0, std_nxt, PROB_DELTA);
              n_res = n_res + 2'd1;
              halt_nxt = 1'b1; phase_nxt = PH_DELTA; vv_nxt = 28'd0; vc_nxt = 3'd0;
            end else begin
              vv_nxt = {vv_nxt[20:0], b[6:0]};
              if (!b[7]) begin
                tick_nxt = tick_nxt + {4'd0, vv_nxt};
                vv_nxt = 28'd0; vc_nxt = 3'd0; phase_nxt = PH_STATUS;
              end
            end
          end
          PH_STATUS: begin
            is_st = b[7];
            t = is_st ? b : rs_nxt;
            cs_nxt = t;
            if (t[7] && t[7:4] != 4'hF) phase_nxt = PH_DATA1;
            else if (t == 8'hFF) phase_nxt = PH_MTYPE;
            else if (t == 8'hF0 || t == 8'hF7) phase_nxt = PH_SLEN;
            else begin
              res[n_res] = mk_res(KIND_WARN, tick_nxt, evc_nxt, t, 8'd0, 8'd0, 8'd0,
                                  29'd0, std_nxt, PROB_UNKNOWN);
              n_res = n_res + 2'd1;
              rs_nxt = cs_nxt; evc_nxt = evc_nxt + 32'd1; phase_nxt = PH_DELTA;
            end
            again = !is_st;
          end
          PH_DATA1: begin
            if (cs_nxt[7:4] == 4'hC || cs_nxt[7:4] == 4'hD) begin
              res[n_res] = mk_res(KIND_CHANNEL, tick_nxt, evc_nxt, cs_nxt, b, 8'd0, 8'd0,
                                  29'd0, std_nxt, PROB_NONE);
              n_res = n_res + 2'd1;
              rs_nxt = cs_nxt; evc_nxt = evc_nxt + 32'd1; phase_nxt = PH_DELTA;
            end else begin
              fd_nxt = b; phase_nxt = PH_DATA2;
            end
          end
          PH_DATA2: begin
            res[n_res] = mk_res(KIND_CHANNEL, tick_nxt, evc_nxt, cs_nxt, fd_nxt, b, 8'd0,
                                29'd0, std_nxt, PROB_NONE);
            n_res = n_res + 2'd1;
            rs_nxt = cs_nxt; evc_nxt = evc_nxt + 32'd1; phase_nxt = PH_DELTA;
          end
          PH_MTYPE: begin
            mk_nxt = b; phase_nxt = PH_MLEN;
          end
          PH_MLEN, PH_SLEN: begin
            vc_nxt = vcount;
            if (vcount > 3'(VARLEN_MAX_BYTES)) begin
              res[n_res] = mk_res(KIND_WARN, tick_nxt, evc_nxt, cs_nxt, 8'd0, 8'd0, 8'd0,
                                  29'd0, std_nxt, PROB_DELTA);
              n_res = n_res + 2'd1;
              halt_nxt = 1'b1; phase_nxt = PH_DELTA; vv_nxt = 28'd0; vc_nxt = 3'd0;
            end else begin
              vv_nxt = {vv_nxt[20:0], b[6:0]};
              if (!b[7]) begin
                if (phase_nxt == PH_MLEN) begin
                  len = {1'b0, vv_nxt};
                  vv_nxt = 28'd0; vc_nxt = 3'd0;
                  bl_nxt = len; bp_nxt = 29'd0;
                  if (meta_mismatch(mk_nxt, len)) begin
                    res[n_res] = mk_res(KIND_WARN, tick_nxt, evc_nxt, cs_nxt, mk_nxt, 8'd0,
                                        8'd0, len, std_nxt, PROB_META_LEN);
                    n_res = n_res + 2'd1;
                  end
                  if (meta_emitted(mk_nxt)) begin
                    res[n_res] = mk_res(KIND_META, tick_nxt, evc_nxt, cs_nxt, mk_nxt, 8'd0,
                                        8'd0, len, std_nxt, PROB_NONE);
                    n_res = n_res + 2'd1;
                  end
                  if (len == 29'd0) begin
                    if (mk_nxt == META_EOT) begin
                      res[n_res] = mk_res(KIND_EOT, tick_nxt, evc_nxt, cs_nxt, mk_nxt, 8'd0,
                                          8'd0, 29'd0, std_nxt, PROB_NONE);
                      n_res = n_res + 2'd1;
                      halt_nxt = 1'b1; phase_nxt = PH_DELTA;
                    end else begin
                      rs_nxt = cs_nxt; evc_nxt = evc_nxt + 32'd1; phase_nxt = PH_DELTA;
                    end
                  end else begin
                    phase_nxt = PH_MBODY;
                  end
                end else begin
                  len = {1'b0, vv_nxt} + {28'd0, (cs_nxt == 8'hF0)};
                  vv_nxt = 28'd0; vc_nxt = 3'd0;
                  bl_nxt = len; bp_nxt = 29'd0; hits_nxt = 4'hF;
                  res[n_res] = mk_res(KIND_SYSEX, tick_nxt, evc_nxt, cs_nxt, 8'd0, 8'd0,
                                      8'd0, len, std_nxt, PROB_NONE);
                  n_res = n_res + 2'd1;
                  phase_nxt = PH_SBODY;
                  if (len == 29'd0) begin
                    rs_nxt = cs_nxt; evc_nxt = evc_nxt + 32'd1; phase_nxt = PH_DELTA;
                  end else if (cs_nxt == 8'hF0) begin
                    sx_do = 1'b1; sx_b = 8'hF0;
                  end
                end
              end
            end
          end
          PH_MBODY: begin
            len = bp_nxt + bl_nxt;
            if (meta_emitted(mk_nxt) && len >= 29'd1 && len <= 29'(META_STORE_LIMIT)) begin
              res[n_res] = mk_res(KIND_PAYLOAD, tick_nxt, evc_nxt, cs_nxt, mk_nxt, 8'd0, b,
                                  len, std_nxt, PROB_NONE);
              n_res = n_res + 2'd1;
            end
            bp_nxt = bp_nxt + 29'd1; bl_nxt = bl_nxt - 29'd1;
            if (bl_nxt == 29'd0) begin
              if (mk_nxt == META_EOT) begin
                res[n_res] = mk_res(KIND_EOT, tick_nxt, evc_nxt, cs_nxt, mk_nxt, 8'd0,
                                    8'd0, 29'd0, std_nxt, PROB_NONE);
                n_res = n_res + 2'd1;
                halt_nxt = 1'b1; phase_nxt = PH_DELTA;
              end else begin
                rs_nxt = cs_nxt; evc_nxt = evc_nxt + 32'd1; phase_nxt = PH_DELTA;
              end
            end
          end
          PH_SBODY: begin
            if (bl_nxt == 29'd0) begin
              rs_nxt = cs_nxt; evc_nxt = evc_nxt + 32'd1; phase_nxt = PH_DELTA;
            end else begin
              sx_do = 1'b1; sx_b = b;
            end
          end
          default: phase_nxt = PH_DELTA;
        endcase

        // One sysex body byte: pattern match, then payload result
        if (sx_do) begin
          total = bp_nxt + bl_nxt;
          for (int i = 0; i < 4; i++) begin
            if (bp_nxt >= pat_len(2'(i)) || pat_byte(2'(i), bp_nxt[3:0]) != sx_b)
              hits_nxt[i] = 1'b0;
          end
          bp_nxt = bp_nxt + 29'd1; bl_nxt = bl_nxt - 29'd1;
          if (bl_nxt == 29'd0) begin
            for (int i = 0; i < 4; i++) begin
              if (hits_nxt[i] && total == pat_len(2'(i))) std_nxt = 3'(i + 1);
            end
          end
          res[n_res] = mk_res(KIND_PAYLOAD, tick_nxt, evc_nxt, cs_nxt, 8'd0, 8'd0, sx_b,
                              total, std_nxt, PROB_NONE);
          n_res = n_res + 2'd1;
          if (bl_nxt == 29'd0) begin
            rs_nxt = cs_nxt; evc_nxt = evc_nxt + 32'd1; phase_nxt = PH_DELTA;
          end
        end
      end
    end

    if (n_res != 2'd0) res[n_res - 2'd1].last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA; rs_r <= 8'd0; cs_r <= 8'd0; tick_r <= 32'd0; evc_r <= 32'd0;
      vv_r <= 28'd0; vc_r <= 3'd0; fd_r <= 8'd0; mk_r <= 8'd0; bl_r <= 29'd0;
      bp_r <= 29'd0; hits_r <= 4'hF; std_r <= 3'd0; halt_r <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt; rs_r <= rs_nxt; cs_r <= cs_nxt; tick_r <= tick_nxt;
      evc_r <= evc_nxt; vv_r <= vv_nxt; vc_r <= vc_nxt; fd_r <= fd_nxt; mk_r <= mk_nxt;
      bl_r <= bl_nxt; bp_r <= bp_nxt; hits_r <= hits_nxt; std_r <= std_nxt;
      halt_r <= halt_nxt;
    end
  end

  // Result queue: up to three pushes, one pop per cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < n_res) q_r[wp_r + 2'(k)] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 2'd0; rp_r <= 2'd0; cnt_r <= 3'd0;
    end else begin
      if (in_fire) wp_r <= wp_r + n_res;
      if (out_fire) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + (in_fire ? {1'b0, n_res} : 3'd0) - {2'd0, out_fire};
    end
  end

  // Output mapping
  assign head       = q_r[rp_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {6'd0, head.problem, head.standard, head.payload_length, head.payload,
                       head.data_two, head.data_one, head.status, head.event_index,
                       head.tick_time};

endmodule
